// File: sv/iss_pkg.sv
package iss_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int OUT_CW   = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             cmp_clr;
        logic             cmp_en;
        logic [IDX_W-1:0] cmp_idx;
        logic             finish;
        logic             shift_wr;
        logic [IDX_W-1:0] shift_idx;
    } t_seq_ctl;

endpackage

// File: sv/integer_set_store_top.sv
// Channel  | Handshake           | Payload
// input    | i_valid / o_stall   | i_operation, i_value
// result   | o_valid / i_stall   | o_status, o_is_member, o_count_greater,
//          |                     | o_count_smaller, o_set_size
// With n stored values the result is registered once all n entries are scanned and the
// output register is free; the next item is taken after that. A delete whose match sits
// at pos below n - 1 then shifts the entries above pos down to close the gap. The
// single memory port pair and one comparator set limit the walks to one entry per cycle.
// Reset clears the count and all control; memory contents are left as they are.
// The result sits in an output register; a new item may be taken while it waits.
module integer_set_store_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [iss_pkg::OP_W-1:0]    i_operation,
    input  logic signed [iss_pkg::VAL_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic                        o_is_member,
    output logic [iss_pkg::OUT_CW-1:0]  o_count_greater,
    output logic [iss_pkg::OUT_CW-1:0]  o_count_smaller,
    output logic [iss_pkg::OUT_CW-1:0]  o_set_size
);
    import iss_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_data;

    logic [CNT_W-1:0] r_count;
    logic [OP_W-1:0]  r_op;
    logic [VAL_W-1:0] r_value;
    logic [CNT_W-1:0] r_n;

    logic              r_ovalid;
    t_status           r_status;
    logic              r_omember;
    logic [OUT_CW-1:0] r_ogreater;
    logic [OUT_CW-1:0] r_osmaller;
    logic [OUT_CW-1:0] r_osize;

    logic             busy;
    logic             start;
    logic             out_free;
    t_seq_ctl         ctl;
    logic [CNT_W-1:0] greater;
    logic [CNT_W-1:0] smaller;
    logic             member;
    logic [IDX_W-1:0] pos;
    t_status          status;
    logic             ins_wr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;

    assign start    = i_valid && !busy;
    assign out_free = !r_ovalid || !i_stall;

    iss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_op       (r_op),
        .i_n_items  (r_n),
        .i_member   (member),
        .i_pos      (pos),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    iss_cmp u_cmp (
        .i_clk     (i_clk),
        .i_clr     (ctl.cmp_clr),
        .i_en      (ctl.cmp_en),
        .i_value   (r_value),
        .i_data    (r_rd_data),
        .i_idx     (ctl.cmp_idx),
        .o_greater (greater),
        .o_smaller (smaller),
        .o_member  (member),
        .o_pos     (pos)
    );

    always_comb begin
        status = ST_OK;
        ins_wr = 1'b0;
        if (r_op == OP_INSERT) begin
            if (member) begin
                status = ST_PRESENT;
            end else if (r_n >= CNT_W'(CAPACITY)) begin
                status = ST_FULL;
            end else begin
                ins_wr = 1'b1;
            end
        end else if (r_op == OP_DELETE) begin
            if (!member) status = ST_NOT_FOUND;
        end
    end

    always_comb begin
        wr_en   = ctl.shift_wr || (ctl.finish && ins_wr);
        wr_addr = ctl.shift_wr ? ctl.shift_idx : r_n[IDX_W-1:0];
        wr_data = ctl.shift_wr ? r_rd_data : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (ctl.rd_en) r_rd_data <= mem[ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op    <= i_operation;
            r_value <= i_value;
            r_n     <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (ctl.finish) begin
            if (ins_wr) begin
                r_count <= r_n + CNT_W'(1);
            end else if ((r_op == OP_DELETE) && member) begin
                r_count <= r_n - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctl.finish) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (ctl.finish) begin
            r_status   <= status;
            r_omember  <= member;
            r_ogreater <= OUT_CW'(greater);
            r_osmaller <= OUT_CW'(smaller);
            r_osize    <= OUT_CW'(r_n);
        end
    end

    assign o_stall         = busy;
    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_is_member     = r_omember;
    assign o_count_greater = r_ogreater;
    assign o_count_smaller = r_osmaller;
    assign o_set_size      = r_osize;

endmodule

// File: sv/iss_cmp.sv
module iss_cmp (
    input  logic                        i_clk,
    input  logic                        i_clr,
    input  logic                        i_en,
    input  logic [iss_pkg::VAL_W-1:0]   i_value,
    input  logic [iss_pkg::VAL_W-1:0]   i_data,
    input  logic [iss_pkg::IDX_W-1:0]   i_idx,
    output logic [iss_pkg::CNT_W-1:0]   o_greater,
    output logic [iss_pkg::CNT_W-1:0]   o_smaller,
    output logic                        o_member,
    output logic [iss_pkg::IDX_W-1:0]   o_pos
);
    import iss_pkg::*;

    logic [CNT_W-1:0] r_greater, n_greater;
    logic [CNT_W-1:0] r_smaller, n_smaller;
    logic             r_member, n_member;
    logic [IDX_W-1:0] r_pos, n_pos;

    always_comb begin
        n_greater = r_greater;
        n_smaller = r_smaller;
        n_member  = r_member;
        n_pos     = r_pos;
        if (i_clr) begin
            n_greater = '0;
            n_smaller = '0;
            n_member  = 1'b0;
            n_pos     = '0;
        end else if (i_en) begin
            if ($signed(i_data) > $signed(i_value)) begin
                n_greater = r_greater + CNT_W'(1);
            end else if ($signed(i_data) < $signed(i_value)) begin
                n_smaller = r_smaller + CNT_W'(1);
            end else if (!r_member) begin
                n_member = 1'b1;
                n_pos    = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_greater <= n_greater;
        r_smaller <= n_smaller;
        r_member  <= n_member;
        r_pos     <= n_pos;
    end

    assign o_greater = r_greater;
    assign o_smaller = r_smaller;
    assign o_member  = r_member;
    assign o_pos     = r_pos;

endmodule

// File: sv/iss_seq.sv
module iss_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_out_free,
    input  logic [iss_pkg::OP_W-1:0]    i_op,
    input  logic [iss_pkg::CNT_W-1:0]   i_n_items,
    input  logic                        i_member,
    input  logic [iss_pkg::IDX_W-1:0]   i_pos,
    output logic                        o_busy,
    output iss_pkg::t_seq_ctl           o_ctl
);
    import iss_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_rvalid;
    logic [IDX_W-1:0] r_raddr;
    logic             rd_en;
    logic             walk_done;
    logic             do_shift;
    logic [CNT_W-1:0] pos_next;

    assign pos_next  = CNT_W'(i_pos) + CNT_W'(1);
    assign do_shift  = (i_op == OP_DELETE) && i_member && (pos_next < i_n_items);
    assign rd_en     = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_addr < i_n_items);
    assign walk_done = !rd_en && !r_rvalid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (walk_done) n_state = S_POST;
            end
            S_POST: begin
                if (i_out_free) n_state = do_shift ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
                if (walk_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_addr = r_addr;
        if ((r_state == S_IDLE) && i_start) begin
            n_addr = '0;
        end else if (rd_en) begin
            n_addr = r_addr + CNT_W'(1);
        end else if ((r_state == S_POST) && i_out_free) begin
            n_addr = pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= rd_en;
        end
        r_addr  <= n_addr;
        r_raddr <= r_addr[IDX_W-1:0];
    end

    always_comb begin
        o_busy          = (r_state != S_IDLE);
        o_ctl.rd_en     = rd_en;
        o_ctl.rd_addr   = r_addr[IDX_W-1:0];
        o_ctl.cmp_clr   = (r_state == S_IDLE) && i_start;
        o_ctl.cmp_en    = (r_state == S_SCAN) && r_rvalid;
        o_ctl.cmp_idx   = r_raddr;
        o_ctl.finish    = (r_state == S_POST) && i_out_free;
        o_ctl.shift_wr  = (r_state == S_SHIFT) && r_rvalid;
        o_ctl.shift_idx = r_raddr - IDX_W'(1);
    end

endmodule
